// File: hw/rtl/wip_pkg.sv
package wip_pkg;

   localparam logic [1:0] CMD_BEGIN = 2'd0;
   localparam logic [1:0] CMD_END   = 2'd1;
   localparam logic [1:0] CMD_FRAME = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [5:0]  slot;
      logic [31:0] time_us;
   } req_type;

   typedef struct packed {
      logic [5:0]  slot_index;
      logic [31:0] average_us;
      logic        last_slot;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BEGIN,
      ST_END_RD,
      ST_END_WR,
      ST_FRM_RD,
      ST_FRM_WR,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic stamp_wr;
      logic total_wr;
      logic walk_sel;
      logic hist_wr;
      logic div_step;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic div_done;
      logic walk_last;
   } dp_sts_type;

endpackage

// File: hw/rtl/wip_ctl.sv
module wip_ctl
   import wip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  command,
   input  dp_sts_type  sts,
   output logic        busy,
   output ctl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (command)
                  CMD_BEGIN: state_in = ST_BEGIN;
                  CMD_END:   state_in = ST_END_RD;
                  CMD_FRAME: state_in = ST_FRM_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_BEGIN:  state_in = ST_IDLE;
         ST_END_RD: state_in = ST_END_WR;
         ST_END_WR: state_in = ST_IDLE;
         ST_FRM_RD: state_in = ST_FRM_WR;
         ST_FRM_WR: state_in = ST_DIV;
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.walk_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FRM_RD;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR:  cmd.clr_step = 1'b1;
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_BEGIN:  cmd.stamp_wr = 1'b1;
         ST_END_RD: cmd.walk_sel = 1'b0;
         ST_END_WR: cmd.total_wr = 1'b1;
         ST_FRM_RD: cmd.walk_sel = 1'b1;
         ST_FRM_WR: begin
            cmd.walk_sel = 1'b1;
            cmd.hist_wr  = 1'b1;
         end
         ST_DIV:    cmd.div_step = 1'b1;
         ST_EMIT:   cmd.emit     = 1'b1;
         default:   cmd          = '0;
      endcase
   end

endmodule

// File: hw/rtl/wip_dp.sv
module wip_dp
   import wip_pkg::*;
#(
   parameter int SLOTS  = 8,
   parameter int WINDOW = 30
)
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type cmd,
   output dp_sts_type  sts,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int SB  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PB  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SW  = 32 + $clog2(WINDOW);
   localparam int RW  = $clog2(WINDOW) + 1;
   localparam int HB  = SW / 2;
   localparam int LB  = SW - HB;
   localparam int MW  = LB + 33;
   localparam int PW  = SW + 33;
   localparam int DCW = 3;
   localparam logic [32:0]    RECIP   = 33'((64'd1 << SW) / 64'(WINDOW));
   localparam logic [RW:0]    WIN_C   = (RW + 1)'(WINDOW);
   localparam logic [DCW-1:0] DIV_LO  = 3'd0;
   localparam logic [DCW-1:0] DIV_HI  = 3'd1;
   localparam logic [DCW-1:0] DIV_SUM = 3'd2;
   localparam logic [DCW-1:0] DIV_REM = 3'd3;
   localparam logic [DCW-1:0] DIV_FIX = 3'd4;

   logic [31:0] stamp_mem [SLOTS];
   logic [31:0] total_mem [SLOTS];
   logic [SW-1:0] sum_mem [SLOTS];
   logic [31:0] hist_mem [SLOTS][WINDOW];

   logic [5:0]     slot_ff;
   logic [31:0]    time_ff;
   logic [SB-1:0]  walk_ff;
   logic [SB-1:0]  walk_in;
   logic [PB-1:0]  hptr_ff;
   logic [PB-1:0]  hptr_in;
   logic [SB-1:0]  clr_s_ff;
   logic [SB-1:0]  clr_s_in;
   logic [PB-1:0]  clr_p_ff;
   logic [PB-1:0]  clr_p_in;
   logic [DCW-1:0] div_cnt_ff;
   logic [DCW-1:0] div_cnt_in;
   logic [SW-1:0]  num_ff;
   logic [SW-1:0]  num_in;
   logic [MW-1:0]  plo_ff;
   logic [MW-1:0]  plo_in;
   logic [MW-1:0]  phi_ff;
   logic [MW-1:0]  phi_in;
   logic [31:0]    qe_ff;
   logic [31:0]    qe_in;
   logic [RW-1:0]  rem_ff;
   logic [RW-1:0]  rem_in;
   logic [31:0]    quo_ff;
   logic [31:0]    quo_in;

   logic [31:0]   stamp_rd_ff;
   logic [31:0]   total_rd_ff;
   logic [SW-1:0] sum_rd_ff;
   logic [31:0]   hist_rd_ff;

   logic          slot_ok;
   logic          clr_row;
   logic          clr_last;
   logic          walk_last;
   logic [SB-1:0] rd_slot;
   logic [SW-1:0] sum_new;
   logic [LB-1:0] mul_a;
   logic [MW-1:0] mul_p;
   logic [PW-1:0] prod;
   logic [SW-1:0] rem_full;

   logic          stamp_we;
   logic [SB-1:0] stamp_wa;
   logic [31:0]   stamp_wd;
   logic          total_we;
   logic [SB-1:0] total_wa;
   logic [31:0]   total_wd;
   logic          sum_we;
   logic [SB-1:0] sum_wa;
   logic [SW-1:0] sum_wd;
   logic          hist_we;
   logic [SB-1:0] hist_ws;
   logic [PB-1:0] hist_wp;
   logic [31:0]   hist_wd;

   assign slot_ok   = {1'b0, slot_ff} < 7'(SLOTS);
   assign clr_row   = cmd.clr_step && (clr_p_ff == '0);
   assign clr_last  = (clr_s_ff == SB'(SLOTS - 1)) && (clr_p_ff == PB'(WINDOW - 1));
   assign walk_last = walk_ff == SB'(SLOTS - 1);
   assign rd_slot   = cmd.walk_sel ? walk_ff : slot_ff[SB-1:0];
   assign sum_new   = sum_rd_ff - SW'(hist_rd_ff) + SW'(total_rd_ff);

   // The mean is the reciprocal product estimate, which is low by at most one,
   // followed by a single compare of the leftover against the window length.
   assign mul_a    = (div_cnt_ff == DIV_LO) ? num_ff[LB-1:0] : LB'(num_ff[SW-1:LB]);
   assign mul_p    = MW'(mul_a) * MW'(RECIP);
   assign prod     = (PW'(phi_ff) << LB) + PW'(plo_ff);
   assign rem_full = num_ff - SW'(qe_ff) * SW'(WINDOW);

   assign stamp_we = clr_row || (cmd.stamp_wr && slot_ok);
   assign stamp_wa = cmd.clr_step ? clr_s_ff : slot_ff[SB-1:0];
   assign stamp_wd = cmd.clr_step ? 32'd0 : time_ff;

   assign total_we = clr_row || (cmd.total_wr && slot_ok) || cmd.hist_wr;
   assign total_wa = cmd.clr_step ? clr_s_ff : (cmd.hist_wr ? walk_ff : slot_ff[SB-1:0]);
   assign total_wd = cmd.total_wr ? (total_rd_ff + (time_ff - stamp_rd_ff)) : 32'd0;

   assign sum_we = clr_row || cmd.hist_wr;
   assign sum_wa = cmd.clr_step ? clr_s_ff : walk_ff;
   assign sum_wd = cmd.clr_step ? '0 : sum_new;

   assign hist_we = cmd.clr_step || cmd.hist_wr;
   assign hist_ws = cmd.clr_step ? clr_s_ff : walk_ff;
   assign hist_wp = cmd.clr_step ? clr_p_ff : hptr_ff;
   assign hist_wd = cmd.clr_step ? 32'd0 : total_rd_ff;

   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[stamp_wa] <= stamp_wd;
      end
      stamp_rd_ff <= stamp_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (total_we) begin
         total_mem[total_wa] <= total_wd;
      end
      total_rd_ff <= total_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_ws][hist_wp] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[walk_ff][hptr_ff];
   end

   always_comb begin
      clr_s_in = clr_s_ff;
      clr_p_in = clr_p_ff;
      if (cmd.clr_step) begin
         if (clr_p_ff == PB'(WINDOW - 1)) begin
            clr_p_in = '0;
            clr_s_in = clr_s_ff + SB'(1);
         end else begin
            clr_p_in = clr_p_ff + PB'(1);
         end
      end
   end

   always_comb begin
      walk_in = walk_ff;
      hptr_in = hptr_ff;
      if (cmd.load) begin
         walk_in = '0;
      end else if (cmd.emit) begin
         if (walk_last) begin
            hptr_in = (hptr_ff == PB'(WINDOW - 1)) ? '0 : hptr_ff + PB'(1);
         end else begin
            walk_in = walk_ff + SB'(1);
         end
      end
   end

   always_comb begin
      div_cnt_in = div_cnt_ff;
      num_in     = num_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;
      qe_in      = qe_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (cmd.hist_wr) begin
         div_cnt_in = DIV_LO;
         num_in     = sum_new;
      end else if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + DCW'(1);
         case (div_cnt_ff)
            DIV_LO:  plo_in = mul_p;
            DIV_HI:  phi_in = mul_p;
            DIV_SUM: qe_in  = prod[SW+31:SW];
            DIV_REM: rem_in = rem_full[RW-1:0];
            DIV_FIX: quo_in = qe_ff + 32'({1'b0, rem_ff} >= WIN_C);
            default: quo_in = quo_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff    <= '0;
         hptr_ff    <= '0;
         clr_s_ff   <= '0;
         clr_p_ff   <= '0;
         div_cnt_ff <= '0;
      end else begin
         walk_ff    <= walk_in;
         hptr_ff    <= hptr_in;
         clr_s_ff   <= clr_s_in;
         clr_p_ff   <= clr_p_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_ff <= req_data.slot;
         time_ff <= req_data.time_us;
      end
      num_ff <= num_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      qe_ff  <= qe_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign sts.clr_done  = clr_last;
   assign sts.div_done  = div_cnt_ff == DIV_FIX;
   assign sts.walk_last = walk_last;

   assign rsp_valid           = cmd.emit;
   assign rsp_data.slot_index = 6'(walk_ff);
   assign rsp_data.average_us = quo_ff;
   assign rsp_data.last_slot  = walk_last;

endmodule

// File: hw/rtl/windowed_interval_profiler_core.sv
// A begin transaction writes the stamp in its one state; an end transaction reads the slot and
// then writes its total. Busy is high after accept. A frame transaction walks every slot: per
// slot a read, a history write, a reciprocal divide for the slot mean and one result strobe
// that cannot be stalled. After reset the history store is cleared one entry per cycle, with
// busy held high; all slot state and the history pointer start at zero.
module windowed_interval_profiler_core
   import wip_pkg::*;
#(
   parameter int SLOTS  = 8,
   parameter int WINDOW = 30
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   wip_ctl u_ctl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_data.command),
      .sts     (sts),
      .busy    (busy),
      .cmd     (cmd)
   );

   wip_dp #(
      .SLOTS  (SLOTS),
      .WINDOW (WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside of a transaction");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_slot) |=> busy)
      else $error("frame walk ended before the last slot");

   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_FRAME) |=> busy)
      else $error("frame transaction not started");
`endif

endmodule

// File: tb/tb_windowed_interval_profiler_core.sv
module tb_windowed_interval_profiler_core;
   import wip_pkg::*;

   localparam int SLOTS = 8;
   localparam int WINDOW = 30;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 2 * (SLOTS * 41 + 1);
   localparam int PHASE_ITEMS = 100;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   class interval_scoreboard;
      logic [31:0] stamp [SLOTS];
      logic [31:0] total [SLOTS];
      logic [31:0] history [SLOTS][WINDOW];
      logic [36:0] running_sum [SLOTS];
      int unsigned frame_ptr;
      rsp_type expected_averages [$];
      int errors;
      int checked;
      int frames;
      int accepted;

      function new();
         for (int s = 0; s < SLOTS; s++) begin
            stamp[s] = '0;
            total[s] = '0;
            running_sum[s] = '0;
            for (int w = 0; w < WINDOW; w++) history[s][w] = '0;
         end
         frame_ptr = 0;
         errors = 0;
         checked = 0;
         frames = 0;
         accepted = 0;
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 50) $display("MISMATCH at %0t: %s", $time, what);
      endtask

      function void note_command(req_type cmd);
         logic [31:0] prior;
         rsp_type avg;
         accepted++;
         case (cmd.command)
            CMD_BEGIN: begin
               if (cmd.slot < SLOTS) stamp[cmd.slot] = cmd.time_us;
            end
            CMD_END: begin
               if (cmd.slot < SLOTS)
                  total[cmd.slot] = total[cmd.slot] + (cmd.time_us - stamp[cmd.slot]);
            end
            CMD_FRAME: begin
               frames++;
               for (int s = 0; s < SLOTS; s++) begin
                  prior = history[s][frame_ptr];
                  history[s][frame_ptr] = total[s];
                  running_sum[s] = running_sum[s] - {5'd0, prior} + {5'd0, total[s]};
                  total[s] = '0;
                  avg.slot_index = 6'(s);
                  avg.average_us = 32'(running_sum[s] / 37'(WINDOW));
                  avg.last_slot = (s == SLOTS - 1);
                  expected_averages.push_back(avg);
               end
               frame_ptr = (frame_ptr == WINDOW - 1) ? 0 : frame_ptr + 1;
            end
            default: begin
            end
         endcase
      endfunction

      task check_average(rsp_type got);
         rsp_type want;
         if (expected_averages.size() == 0) begin
            report_mismatch($sformatf("unexpected result slot %0d average %0d",
                                      got.slot_index, got.average_us));
         end else begin
            want = expected_averages.pop_front();
            checked++;
            if (got.slot_index !== want.slot_index)
               report_mismatch($sformatf("slot_index %0d, expected %0d",
                                         got.slot_index, want.slot_index));
            if (got.average_us !== want.average_us)
               report_mismatch($sformatf("slot %0d average_us %0d, expected %0d",
                                         want.slot_index, got.average_us, want.average_us));
            if (got.last_slot !== want.last_slot)
               report_mismatch($sformatf("slot %0d last_slot %0b, expected %0b",
                                         want.slot_index, got.last_slot, want.last_slot));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;

   interval_scoreboard sb;
   int idle_pct;
   int quiet_cycles = 0;
   logic [31:0] now_us;
   bit open_slot [SLOTS];

   windowed_interval_profiler_core #(
      .SLOTS(SLOTS),
      .WINDOW(WINDOW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_command(req_data);
         if (rsp_valid) sb.check_average(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_command(input logic [1:0] cmd, input logic [5:0] slot,
                               input logic [31:0] stamp);
      req_type item;
      item.command = cmd;
      item.slot = slot;
      item.time_us = stamp;
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_averages.size() != 0) @(posedge clock);
   endtask

   // Mostly begin/end pairs per slot with random spacing, plus frame closes,
   // very long intervals that overflow the totals, and out-of-range noise.
   task automatic random_command(output bit counts);
      int pick;
      int s;
      logic [1:0] cmd;
      logic [5:0] slot;
      pick = $urandom_range(99);
      now_us = now_us + $urandom_range(0, 3000);
      s = $urandom_range(0, SLOTS - 1);
      counts = 1'b1;
      if (pick < 12) begin
         send_command(CMD_FRAME, 6'($urandom_range(0, 63)), now_us);
      end else if (pick < 80) begin
         send_command(open_slot[s] ? CMD_END : CMD_BEGIN, 6'(s), now_us);
         open_slot[s] = !open_slot[s];
      end else if (pick < 86) begin
         now_us = now_us + $urandom;
         send_command(CMD_END, 6'(s), now_us);
         open_slot[s] = 1'b0;
      end else if (pick < 93) begin
         send_command(2'($urandom_range(0, 1)), 6'($urandom_range(SLOTS, 63)), $urandom);
         counts = 1'b0;
      end else begin
         cmd = 2'($urandom_range(0, 3));
         slot = 6'($urandom_range(0, 63));
         send_command(cmd, slot, $urandom);
         counts = (cmd == CMD_FRAME) || (cmd != CMD_UNUSED && slot < SLOTS);
      end
   endtask

   initial begin
      bit counts;
      int counted;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_pct = 0;
      now_us = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_command(CMD_END, 6'd0, 32'h0000_0010);
      send_command(CMD_END, 6'd7, 32'hFFFF_FFFF);
      send_command(CMD_BEGIN, 6'd0, 32'hFFFF_FFF0);
      send_command(CMD_END, 6'd0, 32'h0000_0010);
      send_command(CMD_BEGIN, 6'd7, 32'h0000_0000);
      send_command(CMD_END, 6'd7, 32'hFFFF_FFFF);
      send_command(CMD_END, 6'd7, 32'hFFFF_FFFF);
      send_command(CMD_BEGIN, 6'd8, 32'h0000_0005);
      send_command(CMD_END, 6'd63, 32'h0000_1234);
      send_command(CMD_BEGIN, 6'd63, 32'hFFFF_FFFF);
      send_command(CMD_UNUSED, 6'd0, 32'hFFFF_FFFF);
      send_command(CMD_UNUSED, 6'd63, 32'h0000_0000);
      send_command(CMD_FRAME, 6'd63, 32'hFFFF_FFFF);
      send_command(CMD_BEGIN, 6'd3, 32'd100);
      send_command(CMD_END, 6'd3, 32'd350);
      send_command(CMD_BEGIN, 6'd1, 32'hAAAA_AAAA);
      send_command(CMD_END, 6'd1, 32'h5555_5555);
      send_command(CMD_FRAME, 6'd0, 32'h0000_0000);
      send_command(CMD_FRAME, 6'd42, 32'h8000_0000);
      wait_for_results();

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 13 : (phase == 1) ? 45 : 0;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            random_command(counts);
            counted += counts;
         end
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_averages.size() != 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived",
                                      sb.expected_averages.size()));
      $display("Ran %0d transactions with %0d frame closes; %0d slot averages checked.",
               sb.accepted, sb.frames, sb.checked);
      $display("Sender idled at 13, 45 and 0 percent, draining results between phases.");
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
